FILE: src/cdid_pkg.sv
package cdid_pkg;

    localparam int OFFSET_BITS = 19;
    localparam int S_TDATA_W   = ((OFFSET_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W   = 32;

    // offset + lead-in fits one bit more than the offset
    localparam int X_W   = OFFSET_BITS + 1;
    // (2^OFFSET_BITS + 150) / 75 < 2^(OFFSET_BITS-6)
    localparam int SEC_W = OFFSET_BITS - 6;

    localparam int          DIV75_SHIFT = 30;
    localparam logic [23:0] DIV75_MULT  = 24'd14316558;
    localparam int          PROD_W      = X_W + 24;

    localparam int          DIV10_SHIFT = 19;
    localparam logic [15:0] DIV10_MULT  = 16'd52429;
    localparam int          P10_W       = SEC_W + DIV10_SHIFT;

    localparam int DSUM_W  = 6;
    localparam int SUM_W   = 8;
    localparam int COUNT_W = 8;
    localparam int T_W     = 16;

    localparam logic [X_W-1:0]     LEADIN_FRAMES = X_W'(150);
    localparam logic [SEC_W-1:0]   LEADIN_SECS   = SEC_W'(2);
    localparam logic [SUM_W:0]     SUM_MODULUS   = 9'd255;
    localparam logic [COUNT_W-1:0] COUNT_MAX     = 8'd255;
    localparam logic [31:0]        SECONDS_MAX   = 32'd65535;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_MUL  = 6'b000010,
        ST_QUOT = 6'b000100,
        ST_DIG  = 6'b001000,
        ST_ACC  = 6'b010000,
        ST_FIN  = 6'b100000
    } cdid_state_t;

    typedef struct packed {
        logic load_in;
        logic mul;
        logic quot;
        logic dig;
        logic acc;
        logic fin_load;
    } cdid_cmd_t;

    typedef struct packed {
        logic leadout;
        logic v_zero;
        logic out_free;
    } cdid_status_t;

endpackage

FILE: src/cdid_ctrl.sv
module cdid_ctrl
    import cdid_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    output logic         in_ready,
    input  cdid_status_t status,
    output cdid_cmd_t    cmd,
    output cdid_state_t  state
);

    cdid_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_valid) state_next = ST_MUL;
            ST_MUL:  state_next = ST_QUOT;
            ST_QUOT: state_next = status.leadout ? ST_FIN : ST_DIG;
            ST_DIG:  if (status.v_zero) state_next = ST_ACC;
            ST_ACC:  state_next = ST_IDLE;
            ST_FIN:  if (status.out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    assign in_ready     = (state_reg == ST_IDLE);
    assign cmd.load_in  = (state_reg == ST_IDLE) && in_valid;
    assign cmd.mul      = (state_reg == ST_MUL);
    assign cmd.quot     = (state_reg == ST_QUOT);
    assign cmd.dig      = (state_reg == ST_DIG) && !status.v_zero;
    assign cmd.acc      = (state_reg == ST_ACC);
    assign cmd.fin_load = (state_reg == ST_FIN) && status.out_free;
    assign state        = state_reg;

endmodule

FILE: src/cdid_dp.sv
module cdid_dp
    import cdid_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cdid_cmd_t            cmd,
    output cdid_status_t         status,
    input  logic [OFFSET_BITS-1:0] entry_offset,
    input  logic                 is_leadout,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [M_TDATA_W-1:0] disc_id
);

    logic [X_W-1:0]     x_reg;
    logic               leadout_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [SEC_W-1:0]   secs_reg;
    logic [SEC_W-1:0]   v_reg;
    logic [DSUM_W-1:0]  dsum_reg;
    logic [SUM_W-1:0]   total_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [SEC_W-1:0]   first_reg;
    logic               out_valid_reg;
    logic [M_TDATA_W-1:0] out_reg;

    logic [SEC_W-1:0]   secs_w;
    logic [P10_W-1:0]   p10;
    logic [SEC_W-1:0]   q10;
    logic [SEC_W-1:0]   q10x10;
    logic [3:0]         digit;
    logic [SUM_W:0]     sum_wide;
    logic [SUM_W-1:0]   total_next;
    logic [SEC_W-1:0]   diff;
    logic [31:0]        diff_ext;
    logic [T_W-1:0]     t_sat;

    assign secs_w = prod_reg[DIV75_SHIFT +: SEC_W];

    // one decimal digit per step: q = v/10, r = v - 10q
    assign p10    = P10_W'(v_reg) * P10_W'(DIV10_MULT);
    assign q10    = p10[DIV10_SHIFT +: SEC_W];
    assign q10x10 = (q10 << 3) + (q10 << 1);
    assign digit  = 4'(v_reg - q10x10);

    assign sum_wide   = {1'b0, total_reg} + (SUM_W + 1)'(dsum_reg);
    assign total_next = (sum_wide >= SUM_MODULUS) ? SUM_W'(sum_wide - SUM_MODULUS)
                                                  : sum_wide[SUM_W-1:0];

    assign diff     = (secs_reg > first_reg) ? (secs_reg - first_reg) : '0;
    assign diff_ext = 32'(diff);
    assign t_sat    = (diff_ext > SECONDS_MAX) ? T_W'(SECONDS_MAX) : diff_ext[T_W-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            leadout_reg <= is_leadout;
            x_reg       <= is_leadout ? X_W'(entry_offset)
                                      : X_W'(entry_offset) + LEADIN_FRAMES;
        end
        if (cmd.mul) begin
            prod_reg <= PROD_W'(x_reg) * PROD_W'(DIV75_MULT);
        end
        if (cmd.quot) begin
            secs_reg <= secs_w;
            v_reg    <= secs_w;
            dsum_reg <= '0;
        end else if (cmd.dig) begin
            v_reg    <= q10;
            dsum_reg <= dsum_reg + DSUM_W'(digit);
        end
        if (cmd.fin_load) begin
            out_reg <= {total_reg, t_sat, count_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg     <= '0;
            count_reg     <= '0;
            first_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.acc) begin
                total_reg <= total_next;
                if (count_reg == '0) begin
                    // offset/75 = (offset+150)/75 - 2
                    first_reg <= secs_reg - LEADIN_SECS;
                end
                if (count_reg != COUNT_MAX) begin
                    count_reg <= count_reg + 1'b1;
                end
            end else if (cmd.fin_load) begin
                total_reg <= '0;
                count_reg <= '0;
                first_reg <= '0;
            end
            if (cmd.fin_load) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.leadout  = leadout_reg;
    assign status.v_zero   = (v_reg == '0);
    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign disc_id         = out_reg;

endmodule

FILE: src/cd_toc_disc_id_core.sv
// A track word steps through MUL, QUOT, the DIG loop (one decimal digit of its
// seconds per step) and ACC; a lead-out word goes through MUL, QUOT and FIN.
// Words are taken one at a time, only in IDLE, and the digit loop sets how long a
// track word takes; a lead-out also waits while the previous disc ID is still held.
// The disc ID sits in an output register, so the next disc can start while it waits.
// Reset: aresetn is synchronous, active low; it clears the running sum, count,
// first-track seconds and the output valid.
module cd_toc_disc_id_core
    import cdid_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,   // entry_offset
    input  logic                 s_axis_tuser,   // is_leadout
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata    // disc_id
);

    cdid_cmd_t    cmd;
    cdid_status_t status;
    cdid_state_t  state;

    cdid_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd),
        .state    (state)
    );

    cdid_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .entry_offset (s_axis_tdata[OFFSET_BITS-1:0]),
        .is_leadout   (s_axis_tuser),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .disc_id      (m_axis_tdata)
    );

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while previous word in progress");

    a_fin_loads_out: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.fin_load |=> m_axis_tvalid)
        else $error("disc ID not presented after lead-out");

    a_fin_only_in_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.fin_load |-> state == ST_FIN && status.leadout)
        else $error("output load outside lead-out finish");

    a_acc_only_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.acc |-> !status.leadout)
        else $error("digit sum accumulated on lead-out");
`endif

endmodule

FILE: dv/cd_toc_disc_id_checker.sv
module cd_toc_disc_id_checker
    import cdid_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,   // entry_offset
    input  logic                 s_axis_tuser,   // is_leadout
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    input  logic [M_TDATA_W-1:0] m_axis_tdata,   // disc_id
    output int                   mismatches,
    output int                   ids_pending
);

    localparam int unsigned LEAD_IN_FRAMES = 150;
    localparam int unsigned FPS            = 75;
    localparam int unsigned SUM_MOD        = 255;
    localparam int unsigned T_MAX          = 65535;
    localparam int          REPORT_MAX     = 10;

    logic [31:0] disc_ids_due[$];
    logic [7:0]  sum_mod255;
    logic [7:0]  track_count;
    int unsigned first_secs;
    int          bad_words;

    initial begin
        mismatches  = 0;
        ids_pending = 0;
        bad_words   = 0;
        sum_mod255  = '0;
        track_count = '0;
        first_secs  = 0;
    end

    always @(posedge aclk) begin : follow_toc
        logic [OFFSET_BITS-1:0] ofs;
        int unsigned            secs;
        int unsigned            dsum;
        int unsigned            end_secs;
        int unsigned            t;
        logic [31:0]            want;
        if (!aresetn) begin
            disc_ids_due.delete();
            sum_mod255  = '0;
            track_count = '0;
            first_secs  = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                ofs = s_axis_tdata[OFFSET_BITS-1:0];
                if (!s_axis_tuser) begin
                    secs = (ofs + LEAD_IN_FRAMES) / FPS;
                    dsum = 0;
                    while (secs != 0) begin
                        dsum += secs % 10;
                        secs /= 10;
                    end
                    if (track_count == 8'd0)
                        first_secs = ofs / FPS;
                    sum_mod255 = 8'((sum_mod255 + dsum) % SUM_MOD);
                    if (track_count != 8'hff)
                        track_count++;
                end else begin
                    end_secs = ofs / FPS;
                    t = (end_secs > first_secs) ? end_secs - first_secs : 0;
                    if (t > T_MAX)
                        t = T_MAX;
                    disc_ids_due.push_back({sum_mod255, 16'(t), track_count});
                    sum_mod255  = '0;
                    track_count = '0;
                    first_secs  = 0;
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (disc_ids_due.size() == 0) begin
                    bad_words++;
                    if (bad_words <= REPORT_MAX)
                        $display("%0t: unexpected disc id word %h", $realtime, m_axis_tdata);
                end else begin
                    want = disc_ids_due.pop_front();
                    if (m_axis_tdata !== want) begin
                        bad_words++;
                        if (bad_words <= REPORT_MAX)
                            $display("%0t: disc id mismatch: expected %h got %h",
                                     $realtime, want, m_axis_tdata);
                    end
                end
            end
        end
        ids_pending <= disc_ids_due.size();
        mismatches  <= bad_words;
    end

endmodule

FILE: dv/testbench.sv
module testbench;
    import cdid_pkg::*;

    localparam int          TARGET_WORDS = 850;
    localparam int unsigned OFS_MAX      = (1 << OFFSET_BITS) - 1;
    localparam int          HOLD_CYCLES  = 500;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;
    logic                 s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;

    int mismatches;
    int ids_pending;
    int words_sent;
    bit no_idle;
    bit hold_req;

    always #2 aclk = ~aclk;

    cd_toc_disc_id_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    cd_toc_disc_id_checker chk (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .mismatches    (mismatches),
        .ids_pending   (ids_pending)
    );

    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_word(input int unsigned ofs, input logic leadout);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= S_TDATA_W'(ofs[OFFSET_BITS-1:0]);
        s_axis_tuser  <= leadout;
        do @(posedge aclk); while (!s_axis_tready);
        words_sent++;
    endtask

    // non-decreasing track offsets, then a lead-out at or past the last one
    task automatic send_sane_disc(input int tracks);
        int unsigned cur;
        cur = $urandom_range(0, 60000);
        for (int i = 0; i < tracks; i++) begin
            send_word(cur, 1'b0);
            cur += $urandom_range(1, 40000);
            if (cur > OFS_MAX)
                cur = OFS_MAX;
        end
        send_word(cur, 1'b1);
    endtask

    task automatic send_noise_disc(input int tracks);
        for (int i = 0; i < tracks; i++)
            send_word($urandom_range(0, OFS_MAX), 1'b0);
        send_word($urandom_range(0, OFS_MAX), 1'b1);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge aclk); while (ids_pending != 0);
    endtask

    initial begin
        m_axis_tready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (no_idle) begin
                m_axis_tready <= 1'b1;
                @(posedge aclk);
            end else begin
                int r;
                r = $urandom_range(0, 99);
                if (r < 65) begin
                    m_axis_tready <= 1'b1;
                    repeat ($urandom_range(1, 8)) @(posedge aclk);
                end else if (r < 95) begin
                    m_axis_tready <= 1'b0;
                    repeat ($urandom_range(1, 4)) @(posedge aclk);
                end else begin
                    m_axis_tready <= 1'b0;
                    repeat ($urandom_range(15, 60)) @(posedge aclk);
                end
            end
        end
    end

    initial begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        int discs;
        int r;
        aresetn       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        words_sent = 0;
        no_idle    = 1'b0;
        hold_req   = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty discs at both ends of the offset range, then a one-track disc spanning it
        send_word(0, 1'b1);
        send_word(OFS_MAX, 1'b1);
        send_word(0, 1'b0);
        send_word(OFS_MAX, 1'b1);
        // lead-out ahead of the first track
        send_word(OFS_MAX, 1'b0);
        send_word(74, 1'b1);
        // lead-out in the same second as the first track
        send_word(7500, 1'b0);
        send_word(7574, 1'b1);
        // digit carries and second boundaries
        send_word(0, 1'b0);
        send_word(74, 1'b0);
        send_word(75, 1'b0);
        send_word(149, 1'b0);
        send_word(7349, 1'b0);
        send_word(74850, 1'b0);
        send_word(749849, 1'b0);
        send_word(OFS_MAX, 1'b0);
        send_word(OFS_MAX, 1'b1);
        no_idle = 1'b1;
        send_sane_disc(4);
        no_idle = 1'b0;
        wait_drained();

        discs = 0;
        while (words_sent < TARGET_WORDS) begin
            no_idle = ($urandom_range(0, 3) == 0);
            if (discs == 8) begin
                // count saturates past 255 tracks
                send_noise_disc(300);
            end else if (discs == 15) begin
                hold_req = 1'b1;
                for (int i = 0; i < 8; i++)
                    send_word($urandom_range(0, OFS_MAX), 1'b1);
            end else if (discs == 30) begin
                wait_drained();
                send_sane_disc($urandom_range(1, 10));
            end else begin
                r = $urandom_range(0, 99);
                if (r < 80)
                    send_sane_disc($urandom_range(1, 20));
                else if (r < 90)
                    send_noise_disc($urandom_range(0, 5));
                else
                    send_word($urandom_range(0, OFS_MAX), 1'b1);
            end
            discs++;
        end
        no_idle = 1'b0;
        s_axis_tvalid <= 1'b0;

        wait_drained();
        repeat (20) @(posedge aclk);
        if (mismatches == 0 && ids_pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
